/* sv/ewcs_pkg.sv */
package ewcs_pkg;

   // Default sizes and register reset values
   localparam int WINDOW_DEPTH_DEF = 8;
   localparam int NUM_CLASSES_DEF  = 16;

   localparam logic [15:0] ALPHA_RST  = 16'd19661;
   localparam logic [31:0] GAP_RST    = 32'd1000;
   localparam logic [3:0]  WINDOW_RST = 4'd8;

   localparam int CSR_AW = 4;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_ALPHA  = 2'd0,
      REG_GAP    = 2'd1,
      REG_WINDOW = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [47:0] now_ms;
      logic [3:0]  class_id;
      logic [15:0] confidence;
      logic        entry_valid;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_class;
      logic [15:0] smoothed;
      logic        last_result;
   } rsp_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      logic        frame_start;
      logic        ring_clear;
      logic        entry_write;
      logic        frame_end;
      logic [3:0]  cls;
      logic [15:0] conf;
   } cmd_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic [31:0] gap_ms;
      logic [3:0]  window;
   } cfg_type;

   typedef enum logic [3:0] {
      S_CLRALL,
      S_IDLE,
      S_NORM,
      S_CLRROW,
      S_WRITE,
      S_RD,
      S_MUL,
      S_ACC,
      S_CEND,
      S_DIV,
      S_EMIT,
      S_NEXTC,
      S_FLUSH
   } state_type;

endpackage

/* sv/ewcs_front.sv */
module ewcs_front #(
   parameter int NUM_CLASSES = ewcs_pkg::NUM_CLASSES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ewcs_pkg::req_type  req_data,
   input  ewcs_pkg::cfg_type  cfg,
   input  logic               q_full,
   input  logic               init_busy,
   output logic               q_push,
   output ewcs_pkg::cmd_type  q_cmd
);

   logic        mid_frame_ff, mid_frame_in;
   logic [47:0] prev_time_ff, prev_time_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [47:0] diff;
   logic        gap_hit;

   assign req_ready = !q_full && !init_busy;
   assign q_push    = req_valid && req_ready;

   // Gap test against previous frame timestamp; backward time never clears
   assign diff    = req_data.now_ms - prev_time_ff;
   assign gap_hit = prev_valid_ff && (req_data.now_ms >= prev_time_ff) &&
                    (diff > {16'b0, cfg.gap_ms});

   // Classify the transaction
   always_comb begin
      q_cmd.frame_start = !mid_frame_ff;
      q_cmd.ring_clear  = !mid_frame_ff && gap_hit;
      q_cmd.entry_write = req_data.entry_valid &&
                          ({3'b0, req_data.class_id} < 7'(NUM_CLASSES));
      q_cmd.frame_end   = req_data.frame_end;
      q_cmd.cls         = req_data.class_id;
      q_cmd.conf        = req_data.confidence;
      mid_frame_in      = mid_frame_ff;
      prev_time_in      = prev_time_ff;
      prev_valid_in     = prev_valid_ff;
      if (q_push) begin
         if (!mid_frame_ff) begin
            prev_time_in  = req_data.now_ms;
            prev_valid_in = 1'b1;
         end
         mid_frame_in = !req_data.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_frame_ff  <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_time_ff  <= '0;
      end else begin
         mid_frame_ff  <= mid_frame_in;
         prev_valid_ff <= prev_valid_in;
         prev_time_ff  <= prev_time_in;
      end
   end

endmodule

/* sv/ewcs_fifo.sv */
module ewcs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ewcs_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ewcs_pkg::cmd_type head_data
);

   // Two-entry command queue
   ewcs_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   no_overflow_a: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("queue overflow");
   no_underflow_a: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue underflow");

endmodule

/* sv/ewcs_back.sv */
module ewcs_back #(
   parameter int WINDOW_DEPTH = ewcs_pkg::WINDOW_DEPTH_DEF,
   parameter int NUM_CLASSES  = ewcs_pkg::NUM_CLASSES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ewcs_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  ewcs_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              init_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ewcs_pkg::rsp_type rsp_data
);

   localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int AGE_W     = $clog2(WINDOW_DEPTH + 1);
   localparam int ADDR_W    = SLOT_W + CLS_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int DEN_W     = 33 + AGE_W;
   localparam int NUM_W     = 49 + AGE_W;

   ewcs_pkg::state_type state_ff, state_in;
   logic                init_ff, init_in;
   ewcs_pkg::cmd_type   cmd_ff, cmd_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic [AGE_W-1:0]    held_ff, held_in;
   logic [AGE_W-1:0]    age_ff, age_in;
   logic [CLS_W-1:0]    cls_ff, cls_in;
   logic [ADDR_W:0]     sweep_ff, sweep_in;
   logic [32:0]         weight_ff, weight_in;
   logic [32:0]         wnext_ff, wnext_in;
   logic [48:0]         prod_ff, prod_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic                any_ff, any_in;
   logic [15:0]         q_ff, q_in;
   logic [3:0]          bit_ff, bit_in;
   ewcs_pkg::rsp_type   pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ewcs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // Frame store: {present, conf}
   logic [16:0]       mem [MEM_DEPTH];
   logic [16:0]       rd_ff;
   logic              mem_we, rd_en;
   logic [ADDR_W-1:0] waddr, rd_addr;
   logic [16:0]       wdata;

   logic [7:0]        weff8, slot8, age8, held8, idx8, next8;
   logic [AGE_W-1:0]  weff;
   logic [16:0]       factor;
   logic [49:0]       wprod;
   logic [NUM_W-1:0]  den_sh;
   logic              out_free;

   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Effective window, 1..WINDOW_DEPTH
   always_comb begin
      if (cfg.window == 4'd0) weff8 = 8'd1;
      else if (8'(cfg.window) > 8'(WINDOW_DEPTH)) weff8 = 8'(WINDOW_DEPTH);
      else weff8 = 8'(cfg.window);
   end
   assign weff  = AGE_W'(weff8);
   assign slot8 = 8'(slot_ff);
   assign age8  = 8'(age_ff);
   assign held8 = 8'(held_ff);

   // Ring index of the frame at the current age, and the next write slot
   assign idx8  = (8'(base_ff) >= age8) ? (8'(base_ff) - age8)
                                        : (8'(base_ff) + weff8 - age8);
   assign next8 = (slot8 + 8'd1 == weff8) ? 8'd0 : (slot8 + 8'd1);

   assign factor = 17'h10000 - {1'b0, cfg.alpha};
   assign wprod  = 50'(weight_ff) * 50'(factor);
   assign den_sh = NUM_W'(den_ff) << bit_ff;

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      held_in       = held_ff;
      age_in        = age_ff;
      cls_in        = cls_ff;
      sweep_in      = sweep_ff;
      weight_in     = weight_ff;
      wnext_in      = wnext_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      any_in        = any_ff;
      q_in          = q_ff;
      bit_in        = bit_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      waddr         = '0;
      wdata         = '0;
      rd_en         = 1'b0;
      rd_addr       = {SLOT_W'(idx8), cls_ff};

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         // Sweep the whole store to zero (reset pass and ring clear)
         ewcs_pkg::S_CLRALL: begin
            mem_we   = 1'b1;
            waddr    = sweep_ff[ADDR_W-1:0];
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (ADDR_W+1)'(MEM_DEPTH - 1)) begin
               sweep_in = '0;
               init_in  = 1'b0;
               state_in = init_ff ? ewcs_pkg::S_IDLE : ewcs_pkg::S_WRITE;
            end
         end
         ewcs_pkg::S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_data;
               q_pop    = 1'b1;
               state_in = ewcs_pkg::S_NORM;
            end
         end
         // Fold write slot into the current window, one subtract a cycle
         ewcs_pkg::S_NORM: begin
            if (slot8 >= weff8) begin
               slot_in = SLOT_W'(slot8 - weff8);
            end else if (cmd_ff.ring_clear) begin
               slot_in  = '0;
               held_in  = '0;
               sweep_in = '0;
               state_in = ewcs_pkg::S_CLRALL;
            end else if (cmd_ff.frame_start) begin
               sweep_in = '0;
               state_in = ewcs_pkg::S_CLRROW;
            end else begin
               state_in = ewcs_pkg::S_WRITE;
            end
         end
         // Clear the row of the frame being built
         ewcs_pkg::S_CLRROW: begin
            mem_we   = 1'b1;
            waddr    = {slot_ff, sweep_ff[CLS_W-1:0]};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff[CLS_W-1:0] == CLS_W'(NUM_CLASSES - 1)) begin
               sweep_in = '0;
               state_in = ewcs_pkg::S_WRITE;
            end
         end
         ewcs_pkg::S_WRITE: begin
            if (cmd_ff.entry_write) begin
               mem_we = 1'b1;
               waddr  = {slot_ff, CLS_W'(cmd_ff.cls)};
               wdata  = {1'b1, cmd_ff.conf};
            end
            if (cmd_ff.frame_end) begin
               held_in   = (held8 > weff8) ? weff : held_ff;
               if (8'(held_in) < weff8) held_in = held_in + 1'b1;
               base_in   = slot_ff;
               slot_in   = SLOT_W'(next8);
               cls_in    = '0;
               age_in    = '0;
               num_in    = '0;
               den_in    = '0;
               weight_in = 33'h1_0000_0000;
               any_in    = 1'b0;
               state_in  = ewcs_pkg::S_RD;
            end else begin
               state_in = ewcs_pkg::S_IDLE;
            end
         end
         // Weighted walk over ages for one class
         ewcs_pkg::S_RD: begin
            rd_en    = 1'b1;
            state_in = ewcs_pkg::S_MUL;
         end
         ewcs_pkg::S_MUL: begin
            prod_in  = 49'(weight_ff) * 49'(rd_ff[15:0]);
            wnext_in = wprod[48:16];
            any_in   = any_ff || rd_ff[16];
            state_in = ewcs_pkg::S_ACC;
         end
         ewcs_pkg::S_ACC: begin
            num_in    = num_ff + NUM_W'(prod_ff);
            den_in    = den_ff + DEN_W'(weight_ff);
            weight_in = wnext_ff;
            age_in    = age_ff + 1'b1;
            state_in  = (age8 + 8'd1 < held8) ? ewcs_pkg::S_RD : ewcs_pkg::S_CEND;
         end
         ewcs_pkg::S_CEND: begin
            q_in     = '0;
            bit_in   = 4'd15;
            state_in = any_ff ? ewcs_pkg::S_DIV : ewcs_pkg::S_NEXTC;
         end
         // Restoring divide, one quotient bit a cycle
         ewcs_pkg::S_DIV: begin
            if (num_ff >= den_sh) begin
               num_in       = num_ff - den_sh;
               q_in[bit_ff] = 1'b1;
            end
            bit_in   = bit_ff - 1'b1;
            if (bit_ff == 4'd0) state_in = ewcs_pkg::S_EMIT;
         end
         // Hold one result back so the final one can be marked
         ewcs_pkg::S_EMIT: begin
            if (!pend_valid_ff) begin
               pend_in       = '{out_class: 4'(cls_ff), smoothed: q_ff, last_result: 1'b0};
               pend_valid_in = 1'b1;
               state_in      = ewcs_pkg::S_NEXTC;
            end else if (out_free) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               pend_in      = '{out_class: 4'(cls_ff), smoothed: q_ff, last_result: 1'b0};
               state_in     = ewcs_pkg::S_NEXTC;
            end
         end
         ewcs_pkg::S_NEXTC: begin
            if (cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
               state_in = ewcs_pkg::S_FLUSH;
            end else begin
               cls_in    = cls_ff + 1'b1;
               age_in    = '0;
               num_in    = '0;
               den_in    = '0;
               weight_in = 33'h1_0000_0000;
               any_in    = 1'b0;
               state_in  = ewcs_pkg::S_RD;
            end
         end
         ewcs_pkg::S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ewcs_pkg::S_IDLE;
            end else if (out_free) begin
               rsp_data_in             = pend_ff;
               rsp_data_in.last_result = 1'b1;
               rsp_valid_in            = 1'b1;
               pend_valid_in           = 1'b0;
               state_in                = ewcs_pkg::S_IDLE;
            end
         end
         default: state_in = ewcs_pkg::S_IDLE;
      endcase
   end

   // Frame store port
   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ewcs_pkg::S_CLRALL;
         init_ff       <= 1'b1;
         sweep_ff      <= '0;
         slot_ff       <= '0;
         held_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         sweep_ff      <= sweep_in;
         slot_ff       <= slot_in;
         held_ff       <= held_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      base_ff     <= base_in;
      age_ff      <= age_in;
      cls_ff      <= cls_in;
      weight_ff   <= weight_in;
      wnext_ff    <= wnext_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      any_ff      <= any_in;
      q_ff        <= q_in;
      bit_ff      <= bit_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   held_bound_a: assert property (@(posedge clock) disable iff (reset)
      8'(held_ff) <= 8'(WINDOW_DEPTH)) else $error("frames held above depth");
   den_floor_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ewcs_pkg::S_DIV |-> den_ff[DEN_W-1:32] != '0)
      else $error("divisor below one");
   flush_push_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ewcs_pkg::S_FLUSH && pend_valid_ff && out_free
      |=> rsp_valid_ff && rsp_data_ff.last_result) else $error("final result lost");
   no_pop_busy_a: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ewcs_pkg::S_IDLE && !init_ff) else $error("pop while busy");

endmodule

/* sv/windowed_ema_class_smoother.sv */
// Windowed EMA class smoother.
// req_* carries classifier entries (valid/ready); the first item of a frame
// samples now_ms, the item with frame_end set closes the frame. rsp_* returns,
// at each frame end, one transaction per class present in the window, in
// ascending class order, with last_result on the final one; no class present
// gives no transaction. psel/penable/pwrite/paddr/pwdata/prdata/pready is the
// register port: alpha at 0x0, reset_gap_ms at 0x4, window_in_use at 0x8.
// Each item passes through the back engine, plus subtract steps when a
// smaller window folds the write slot, plus a row clear on a frame's first
// item, or instead a full store sweep on a gap clear. A frame end walks every
// class over the held frames, divides when the class is present, and ends
// with a flush; the single store read port and the one-bit-a-cycle divider
// set its pace. A two-entry queue lets the front take items while the back is
// busy. Reset zeroes the frame store in a clearing pass, during which
// req_ready is low; registers stay writable. When rsp_ready is low the back
// engine holds its result and stalls, and the queue then backs up req.
module windowed_ema_class_smoother #(
   parameter int WINDOW_DEPTH = ewcs_pkg::WINDOW_DEPTH_DEF,
   parameter int NUM_CLASSES  = ewcs_pkg::NUM_CLASSES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ewcs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ewcs_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ewcs_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   ewcs_pkg::cfg_type cfg_ff, cfg_in;
   ewcs_pkg::cmd_type push_cmd, head_cmd;
   logic              push, q_full, pop, head_valid, init_busy;

   // Register file
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            ewcs_pkg::REG_ALPHA:  cfg_in.alpha  = pwdata[15:0];
            ewcs_pkg::REG_GAP:    cfg_in.gap_ms = pwdata;
            ewcs_pkg::REG_WINDOW: cfg_in.window = pwdata[3:0];
            default: ;
         endcase
      end
      case (paddr[3:2])
         ewcs_pkg::REG_ALPHA:  prdata = {16'b0, cfg_ff.alpha};
         ewcs_pkg::REG_GAP:    prdata = cfg_ff.gap_ms;
         ewcs_pkg::REG_WINDOW: prdata = {28'b0, cfg_ff.window};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha  <= ewcs_pkg::ALPHA_RST;
         cfg_ff.gap_ms <= ewcs_pkg::GAP_RST;
         cfg_ff.window <= ewcs_pkg::WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ewcs_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .init_busy (init_busy),
      .q_push    (push),
      .q_cmd     (push_cmd)
   );

   ewcs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_cmd)
   );

   ewcs_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (head_valid),
      .q_data    (head_cmd),
      .q_pop     (pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/windowed_ema_class_smoother_tb.sv */
module windowed_ema_class_smoother_tb;

   localparam int DEPTH   = ewcs_pkg::WINDOW_DEPTH_DEF;
   localparam int CLASSES = ewcs_pkg::NUM_CLASSES_DEF;
   localparam longint CYCLE_LIMIT = 500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ewcs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ewcs_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ewcs_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   windowed_ema_class_smoother i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow of the smoother state
   logic [15:0] sh_alpha;
   logic [31:0] sh_gap;
   logic [3:0]  sh_window;
   logic [15:0] conf_store [DEPTH][CLASSES];
   logic        seen_store [DEPTH][CLASSES];
   int unsigned slot_ptr;
   int unsigned held_cnt;
   logic [47:0] last_stamp;
   logic        last_stamp_ok;
   logic        in_frame;

   ewcs_pkg::req_type pending_items [$];
   ewcs_pkg::rsp_type smoothed_q [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        hold_sender = 1'b0;
   int unsigned errors = 0;
   longint      cycle_cnt = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned window_eff();
      if (sh_window == 0) return 1;
      if (sh_window > DEPTH) return DEPTH;
      return sh_window;
   endfunction

   function automatic void wipe_ring();
      for (int s = 0; s < DEPTH; s++)
         for (int c = 0; c < CLASSES; c++) begin
            conf_store[s][c] = '0;
            seen_store[s][c] = 1'b0;
         end
      slot_ptr = 0;
      held_cnt = 0;
   endfunction

   // Compute expected smoothed outputs for one accepted transaction
   function automatic void smooth_frame(ewcs_pkg::req_type it);
      int unsigned w;
      int unsigned slot;
      int unsigned idx;
      logic [63:0] factor, weight, num, den;
      bit any;
      ewcs_pkg::rsp_type r;
      int n;
      w = window_eff();
      n = 0;
      if (!in_frame) begin
         if (last_stamp_ok && it.now_ms >= last_stamp &&
             (it.now_ms - last_stamp) > {16'd0, sh_gap})
            wipe_ring();
         last_stamp = it.now_ms;
         last_stamp_ok = 1'b1;
         for (int c = 0; c < CLASSES; c++) begin
            conf_store[slot_ptr % w][c] = '0;
            seen_store[slot_ptr % w][c] = 1'b0;
         end
         in_frame = 1'b1;
      end
      slot = slot_ptr % w;
      if (it.entry_valid && it.class_id < CLASSES) begin
         conf_store[slot][it.class_id] = it.confidence;
         seen_store[slot][it.class_id] = 1'b1;
      end
      if (!it.frame_end) return;
      in_frame = 1'b0;
      if (held_cnt > w) held_cnt = w;
      if (held_cnt < w) held_cnt++;
      slot_ptr = (slot + 1) % w;
      factor = 64'd65536 - {48'd0, sh_alpha};
      for (int c = 0; c < CLASSES; c++) begin
         any = 0;
         for (int a = 0; a < held_cnt; a++)
            if (seen_store[(slot + w - a) % w][c]) any = 1;
         if (!any) continue;
         weight = 64'd1 << 32;
         num = 0;
         den = 0;
         for (int a = 0; a < held_cnt; a++) begin
            idx = (slot + w - a) % w;
            num += weight * conf_store[idx][c];
            den += weight;
            weight = (weight * factor) >> 16;
         end
         r.out_class = c[3:0];
         r.smoothed = 16'(num / den);
         r.last_result = 1'b0;
         smoothed_q.push_back(r);
         n++;
      end
      if (n > 0) smoothed_q[$].last_result = 1'b1;
   endfunction

   // Driver: present pending transactions, idle at random
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            smooth_frame(req_data);
            void'(pending_items.pop_front());
         end
         if ((!req_valid || req_ready) && pending_items.size() > 0) begin
            if (!(req_valid && req_ready) || pending_items.size() > 0) begin
               if (!hold_sender && $urandom_range(99) >= send_idle_pct) begin
                  req_valid <= 1'b1;
                  req_data <= pending_items[0];
               end else
                  req_valid <= 1'b0;
            end
         end else if (req_valid && req_ready)
            req_valid <= 1'b0;
      end
   end

   // Monitor: compare each smoothed transaction against the oldest expectation
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (smoothed_q.size() == 0) begin
               $error("unexpected transaction class=%0d", rsp_data.out_class);
               errors++;
            end else begin
               if (rsp_data.out_class !== smoothed_q[0].out_class) begin
                  $error("out_class exp %0d got %0d", smoothed_q[0].out_class,
                         rsp_data.out_class);
                  errors++;
               end
               if (rsp_data.smoothed !== smoothed_q[0].smoothed) begin
                  $error("smoothed exp %0d got %0d", smoothed_q[0].smoothed,
                         rsp_data.smoothed);
                  errors++;
               end
               if (rsp_data.last_result !== smoothed_q[0].last_result) begin
                  $error("last_result exp %0d got %0d", smoothed_q[0].last_result,
                         rsp_data.last_result);
                  errors++;
               end
               void'(smoothed_q.pop_front());
            end
         end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("windowed_ema_class_smoother test failed");
         $finish;
      end
   end

   task automatic csr_write(ewcs_pkg::reg_idx_type idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ewcs_pkg::CSR_AW'({idx, 2'b00});
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         ewcs_pkg::REG_ALPHA:  sh_alpha = val[15:0];
         ewcs_pkg::REG_GAP:    sh_gap = val;
         ewcs_pkg::REG_WINDOW: begin
            sh_window = val[3:0];
            slot_ptr = slot_ptr % window_eff();
            if (held_cnt > window_eff()) held_cnt = window_eff();
         end
         default: ;
      endcase
   endtask

   // Wait until all items are taken and all results are back, then settle
   task automatic drain();
      wait (pending_items.size() == 0 && !req_valid);
      wait (smoothed_q.size() == 0);
      repeat (2000) @(posedge clock);
   endtask

   function automatic ewcs_pkg::req_type make_item(logic [47:0] t, int cls, int conf,
                                                   bit ev, bit fe);
      ewcs_pkg::req_type it;
      it.now_ms = t;
      it.class_id = cls[3:0];
      it.confidence = conf[15:0];
      it.entry_valid = ev;
      it.frame_end = fe;
      return it;
   endfunction

   // Queue one random frame; mostly small time steps, sometimes gaps or wraps
   task automatic add_frame(ref logic [47:0] t);
      int unsigned n;
      int unsigned sel;
      sel = $urandom_range(19);
      if (sel == 0) t = 48'({$urandom, $urandom});
      else if (sel == 1) t = t - $urandom_range(500);
      else if (sel == 2) t = t + 48'(sh_gap) + 1 + $urandom_range(3);
      else if (sel == 3) t = t + 48'(sh_gap);
      else t = t + $urandom_range(300);
      n = $urandom_range(4);
      for (int i = 0; i <= n; i++)
         pending_items.push_back(make_item(t, $urandom_range(15), $urandom,
                                           $urandom_range(9) != 0, i == n));
   endtask

   initial begin
      logic [47:0] stamp;
      sh_alpha = ewcs_pkg::ALPHA_RST;
      sh_gap = ewcs_pkg::GAP_RST;
      sh_window = ewcs_pkg::WINDOW_RST;
      wipe_ring();
      last_stamp = '0;
      last_stamp_ok = 1'b0;
      in_frame = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, repeated class, empty frame, gaps, backward time
      pending_items.push_back(make_item(48'd0, 0, 16'hFFFF, 1, 0));
      pending_items.push_back(make_item(48'd0, 15, 0, 1, 0));
      pending_items.push_back(make_item(48'd0, 0, 16'h1234, 1, 1));
      pending_items.push_back(make_item(48'd10, 5, 16'h8000, 0, 1));
      pending_items.push_back(make_item(48'd1010, 7, 16'hFFFF, 1, 1));
      pending_items.push_back(make_item(48'd2011, 3, 16'h5555, 1, 1));
      pending_items.push_back(make_item(48'd5, 3, 16'hAAAA, 1, 1));
      pending_items.push_back(make_item(48'hFFFF_FFFF_FFFF, 15, 16'hFFFF, 1, 1));
      pending_items.push_back(make_item(48'hFFFF_FFFF_FFFF, 9, 16'h0001, 1, 1));
      drain();

      csr_write(ewcs_pkg::REG_ALPHA, 32'd0);
      csr_write(ewcs_pkg::REG_GAP, 32'hFFFF_FFFF);
      csr_write(ewcs_pkg::REG_WINDOW, 32'd0);
      stamp = 48'd100;
      for (int i = 0; i < 6; i++) add_frame(stamp);
      drain();
      csr_write(ewcs_pkg::REG_ALPHA, 32'hFFFF);
      csr_write(ewcs_pkg::REG_GAP, 32'd0);
      csr_write(ewcs_pkg::REG_WINDOW, 32'd15);
      for (int i = 0; i < 6; i++) add_frame(stamp);
      drain();

      // Random phases with different idle patterns and settings
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 61 : 0;
         recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 29 : 0;
         csr_write(ewcs_pkg::REG_ALPHA, $urandom);
         csr_write(ewcs_pkg::REG_GAP, $urandom_range(2000));
         csr_write(ewcs_pkg::REG_WINDOW, $urandom_range(15));
         for (int i = 0; i < 9; i++) add_frame(stamp);
         if (ph == 1) begin
            // Midway, hold the sender until every expected result is back
            wait (pending_items.size() < 14);
            hold_sender = 1'b1;
            repeat (2) @(posedge clock);
            wait (!req_valid && smoothed_q.size() == 0);
            hold_sender = 1'b0;
         end
         drain();
      end

      if (errors == 0)
         $display("windowed_ema_class_smoother test passed");
      else
         $display("windowed_ema_class_smoother test failed");
      $finish;
   end
endmodule
